@@ rtl/plc_pkg.sv @@
// Shared constants and types for the pixel luma channel arithmetic block.
`default_nettype none

package plc_pkg;

    // Luma weights in unsigned Q0.16; they sum to exactly 65536.
    localparam logic [15:0] WeightR = 16'd19595;
    localparam logic [15:0] WeightG = 16'd38470;
    localparam logic [15:0] WeightB = 16'd7471;

    // Smallest Q16 luma above 0.255, the lower bound for a real divide.
    localparam logic [23:0] DivMinLuma = 24'd16712;

    // Number of register stages from the input to the output register.
    localparam int NumStages = 6;

    // Operation codes held in the operation_mode register.
    localparam logic [3:0] ModeAdd = 4'd0;
    localparam logic [3:0] ModeSub = 4'd1;
    localparam logic [3:0] ModeMul = 4'd2;
    localparam logic [3:0] ModeDiv = 4'd3;
    localparam logic [3:0] ModeAnd = 4'd4;
    localparam logic [3:0] ModeOr  = 4'd5;
    localparam logic [3:0] ModeXor = 4'd6;
    localparam logic [3:0] ModeMin = 4'd7;
    localparam logic [3:0] ModeMax = 4'd8;

    // One load enable per pipeline stage, stage 1 in bit 0.
    typedef logic [NumStages-1:0] stage_en_t;

endpackage

`default_nettype wire

@@ rtl/plc_if.sv @@
// Handshake channel interfaces for pixels in, pixels out and configuration.
`default_nettype none

interface plc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface plc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

interface plc_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] operation_mode;
    modport source (output valid, output operation_mode, input ready);
    modport sink (input valid, input operation_mode, output ready);
endinterface

`default_nettype wire

@@ rtl/plc_luma.sv @@
// Luma computation: weight products in stage 1, their sum in stage 2.
`default_nettype none

module plc_luma (
    input  logic                clk,
    input  plc_pkg::stage_en_t  en,
    input  logic [7:0]          red,
    input  logic [7:0]          green,
    input  logic [7:0]          blue,
    output logic [7:0]          red_s2,
    output logic [7:0]          green_s2,
    output logic [7:0]          blue_s2,
    output logic [23:0]         luma_s2
);

    logic [7:0]  red_s1_reg;
    logic [7:0]  green_s1_reg;
    logic [7:0]  blue_s1_reg;
    logic [23:0] prod_r_reg;
    logic [23:0] prod_g_reg;
    logic [23:0] prod_b_reg;
    logic [7:0]  red_s2_reg;
    logic [7:0]  green_s2_reg;
    logic [7:0]  blue_s2_reg;
    logic [23:0] luma_reg;

    // Stage 1: one weight multiplication per channel.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            red_s1_reg   <= red;
            green_s1_reg <= green;
            blue_s1_reg  <= blue;
            prod_r_reg   <= 24'({8'b0, plc_pkg::WeightR} * {16'b0, red});
            prod_g_reg   <= 24'({8'b0, plc_pkg::WeightG} * {16'b0, green});
            prod_b_reg   <= 24'({8'b0, plc_pkg::WeightB} * {16'b0, blue});
        end
    end

    // Stage 2: the weights sum to one, so the sum never exceeds 255 in Q8.16.
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            red_s2_reg   <= red_s1_reg;
            green_s2_reg <= green_s1_reg;
            blue_s2_reg  <= blue_s1_reg;
            luma_reg     <= prod_r_reg + prod_g_reg + prod_b_reg;
        end
    end

    assign red_s2   = red_s2_reg;
    assign green_s2 = green_s2_reg;
    assign blue_s2  = blue_s2_reg;
    assign luma_s2  = luma_reg;

endmodule

`default_nettype wire

@@ rtl/plc_chan.sv @@
// Per-channel operation: simple ops, multiply and a two-bit-per-stage divider.
`default_nettype none

module plc_chan (
    input  logic                clk,
    input  plc_pkg::stage_en_t  en,
    input  logic [3:0]          mode,
    input  logic [7:0]          chan,
    input  logic [23:0]         luma,
    output logic [7:0]          result
);

    // One restoring divide step: returns the quotient bit over the new remainder.
    function automatic logic [32:0] div_step(input logic [31:0] rem,
                                             input logic [23:0] dvs,
                                             input logic [2:0]  sh);
        logic [31:0] trial;
        logic [32:0] res;
        trial = {8'b0, dvs} << sh;
        if (rem >= trial)
        begin
            res = {1'b1, rem - trial};
        end
        else
        begin
            res = {1'b0, rem};
        end
        return res;
    endfunction

    logic [7:0]  luma_int;
    logic        luma_frac;
    logic [8:0]  add_sum;
    logic [7:0]  simple_val;
    logic [15:0] chan_x255;
    logic [31:0] numer;
    logic        div_force;
    logic [32:0] st7;
    logic [32:0] st6;
    logic [32:0] st5;
    logic [32:0] st4;
    logic [32:0] st3;
    logic [32:0] st2;
    logic [32:0] st1;
    logic [32:0] st0;
    logic [15:0] mul_hi;
    logic [7:0]  mul_q0;
    logic [8:0]  mul_rem;
    logic [7:0]  mul_q;

    logic [7:0]  simple_s3_reg;
    logic [31:0] prod_s3_reg;
    logic [31:0] rem_s3_reg;
    logic [1:0]  quo_s3_reg;
    logic [23:0] dvs_s3_reg;
    logic        force_s3_reg;

    logic [7:0]  simple_s4_reg;
    logic [7:0]  mul_s4_reg;
    logic [31:0] rem_s4_reg;
    logic [3:0]  quo_s4_reg;
    logic [23:0] dvs_s4_reg;
    logic        force_s4_reg;

    logic [7:0]  other_s5_reg;
    logic [31:0] rem_s5_reg;
    logic [5:0]  quo_s5_reg;
    logic [23:0] dvs_s5_reg;
    logic        force_s5_reg;

    logic [7:0]  result_reg;

    // Stage 3 logic: the operations that need no multiply or divide.
    always_comb
    begin
        luma_int  = luma[23:16];
        luma_frac = |luma[15:0];
        add_sum   = {1'b0, chan} + {1'b0, luma_int};
        case (mode)
            plc_pkg::ModeAdd: simple_val = add_sum[8] ? 8'hFF : add_sum[7:0];
            plc_pkg::ModeSub:
            begin
                // The result is zero whenever the luma exceeds the channel.
                if (chan < luma_int || (chan == luma_int && luma_frac))
                begin
                    simple_val = 8'd0;
                end
                else
                begin
                    simple_val = chan - luma_int - {7'b0, luma_frac};
                end
            end
            plc_pkg::ModeAnd: simple_val = (|(chan & luma_int)) ? 8'hFF : 8'h00;
            plc_pkg::ModeOr:  simple_val = (|(chan | luma_int)) ? 8'hFF : 8'h00;
            plc_pkg::ModeXor: simple_val = (|(chan ^ luma_int)) ? 8'hFF : 8'h00;
            plc_pkg::ModeMin: simple_val = (chan < luma_int) ? chan : luma_int;
            plc_pkg::ModeMax: simple_val = (chan > luma_int) ? chan : luma_int;
            default:          simple_val = 8'd0;
        endcase
    end

    // Stage 3 logic: divide setup and the two top quotient bits.
    always_comb
    begin
        chan_x255 = {chan, 8'b0} - {8'b0, chan};
        numer     = {chan_x255, 16'b0};
        // A quotient of 256 or more saturates, as does a luma at or below 0.255.
        div_force = (numer >= {luma, 8'b0}) || (luma < plc_pkg::DivMinLuma);
        st7       = div_step(numer, luma, 3'd7);
        st6       = div_step(st7[31:0], luma, 3'd6);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            simple_s3_reg <= simple_val;
            prod_s3_reg   <= 32'({24'b0, chan} * {8'b0, luma});
            rem_s3_reg    <= st6[31:0];
            quo_s3_reg    <= {st7[32], st6[32]};
            dvs_s3_reg    <= luma;
            force_s3_reg  <= div_force;
        end
    end

    // Stage 4 logic: product over 255*65536 as a shift and a divide by 255.
    always_comb
    begin
        mul_hi  = prod_s3_reg[31:16];
        mul_q0  = mul_hi[15:8];
        mul_rem = {1'b0, mul_hi[7:0]} + {1'b0, mul_q0};
        mul_q   = mul_q0 + {7'b0, (mul_rem >= 9'd255)} + {7'b0, (mul_rem >= 9'd510)};
        st5     = div_step(rem_s3_reg, dvs_s3_reg, 3'd5);
        st4     = div_step(st5[31:0], dvs_s3_reg, 3'd4);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            simple_s4_reg <= simple_s3_reg;
            mul_s4_reg    <= mul_q;
            rem_s4_reg    <= st4[31:0];
            quo_s4_reg    <= {quo_s3_reg, st5[32], st4[32]};
            dvs_s4_reg    <= dvs_s3_reg;
            force_s4_reg  <= force_s3_reg;
        end
    end

    // Stage 5: two more quotient bits; pick multiply or simple result.
    always_comb
    begin
        st3 = div_step(rem_s4_reg, dvs_s4_reg, 3'd3);
        st2 = div_step(st3[31:0], dvs_s4_reg, 3'd2);
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            other_s5_reg <= (mode == plc_pkg::ModeMul) ? mul_s4_reg : simple_s4_reg;
            rem_s5_reg   <= st2[31:0];
            quo_s5_reg   <= {quo_s4_reg, st3[32], st2[32]};
            dvs_s5_reg   <= dvs_s4_reg;
            force_s5_reg <= force_s4_reg;
        end
    end

    // Stage 6: last quotient bits and the final selection into the output register.
    always_comb
    begin
        st1 = div_step(rem_s5_reg, dvs_s5_reg, 3'd1);
        st0 = div_step(st1[31:0], dvs_s5_reg, 3'd0);
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            if (mode == plc_pkg::ModeDiv)
            begin
                result_reg <= force_s5_reg ? 8'hFF : {quo_s5_reg, st1[32], st0[32]};
            end
            else
            begin
                result_reg <= other_s5_reg;
            end
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

@@ rtl/pixel_luma_channel_arithmetic.sv @@
// Top level: pixel luma channel arithmetic pipeline with stage handshake.
//
//  Channel  | Direction | Payload
//  ---------+-----------+----------------------------------------
//  pix_in   | in        | red_in, green_in, blue_in (8 bits each)
//  pix_out  | out       | red_out, green_out, blue_out (8 bits each)
//  cfg      | in        | operation_mode (4 bits), always ready
//
// One pixel per clock sustained while pix_out is ready; a pixel passes six register
// stages, the output register the last of them, a depth set by the two luma stages
// and the two-bit-per-stage divider.
// Reset clears the stage valid bits and sets operation_mode to add.
// Each stage loads when it is empty or its successor loads, so bubbles close
// up and a stalled output still lets upstream stages fill.
`default_nettype none

module pixel_luma_channel_arithmetic (
    input  logic            clk,
    input  logic            rst_n,
    plc_in_if.sink          pix_in,
    plc_out_if.source       pix_out,
    plc_cfg_if.sink         cfg
);

    localparam int LastStage = plc_pkg::NumStages - 1;

    logic [3:0]           mode_reg;
    logic [LastStage:0]   valid_reg;
    logic [LastStage:0]   valid_next;
    plc_pkg::stage_en_t   stage_en;

    logic [7:0]  red_s2;
    logic [7:0]  green_s2;
    logic [7:0]  blue_s2;
    logic [23:0] luma_s2;

    // Users write mode only with the pipeline empty; the block does not check.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= plc_pkg::ModeAdd;
        end
        else if (cfg.valid && cfg.ready)
        begin
            mode_reg <= cfg.operation_mode;
        end
    end

    // Stage enables ripple back from the output.
    always_comb
    begin
        stage_en[LastStage] = !valid_reg[LastStage] || pix_out.ready;
        for (int i = LastStage - 1; i >= 0; i--)
        begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    // Valid bits travel with the data.
    always_comb
    begin
        valid_next = valid_reg;
        if (stage_en[0])
        begin
            valid_next[0] = pix_in.valid;
        end
        for (int i = 1; i <= LastStage; i++)
        begin
            if (stage_en[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign pix_in.ready  = stage_en[0];
    assign pix_out.valid = valid_reg[LastStage];

    // Luma in stages one and two.
    plc_luma u_luma (
        .clk      (clk),
        .en       (stage_en),
        .red      (pix_in.red_in),
        .green    (pix_in.green_in),
        .blue     (pix_in.blue_in),
        .red_s2   (red_s2),
        .green_s2 (green_s2),
        .blue_s2  (blue_s2),
        .luma_s2  (luma_s2)
    );

    // One operation unit per color channel, stages three to six.
    plc_chan u_chan_red (
        .clk    (clk),
        .en     (stage_en),
        .mode   (mode_reg),
        .chan   (red_s2),
        .luma   (luma_s2),
        .result (pix_out.red_out)
    );

    plc_chan u_chan_green (
        .clk    (clk),
        .en     (stage_en),
        .mode   (mode_reg),
        .chan   (green_s2),
        .luma   (luma_s2),
        .result (pix_out.green_out)
    );

    plc_chan u_chan_blue (
        .clk    (clk),
        .en     (stage_en),
        .mode   (mode_reg),
        .chan   (blue_s2),
        .luma   (luma_s2),
        .result (pix_out.blue_out)
    );

    // An empty output register never holds back the input.
    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[LastStage] |-> pix_in.ready)
        else $error("input not ready with an empty output stage");

    // With every stage full and the output stalled, no transfer is taken in.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg && !pix_out.ready) |-> !pix_in.ready)
        else $error("input ready while the pipeline is full and stalled");

    // An accepted transfer occupies the first stage on the next cycle.
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_in.valid && pix_in.ready) |=> valid_reg[0])
        else $error("accepted transfer missing from the first stage");

endmodule

`default_nettype wire
